/* hdl/icer_pkg.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier package
// Shared constants, register indexes and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package icer_pkg;

   localparam int MAX_PACKET_DEFAULT = 2048;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int LENGTH_W    = 11;
   localparam int USEC_W      = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_OUR_IDENTIFIER = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_OTHER   = 8'd1;

   localparam logic [7:0]  PROTO_ICMP      = 8'd1;
   localparam logic [7:0]  TYPE_ECHO_REPLY = 8'd0;
   localparam int          ICMP_MIN_LEN    = 8;
   localparam int          REPLY_MIN_LEN   = 16;
   localparam logic [33:0] USEC_PER_SEC    = 34'd1000000;
   localparam logic [33:0] USEC_MAX        = 34'd999999;

   // Byte positions inside the IP header.
   localparam int IP_OFS_VERSION_IHL = 0;
   localparam int IP_OFS_TTL         = 8;
   localparam int IP_OFS_PROTOCOL    = 9;

   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_OTHER = 1'b1;

   typedef struct packed {
      logic [7:0]        packet_byte;
      logic              last_byte;
      logic [31:0]       recv_seconds;
      logic [USEC_W-1:0] recv_microseconds;
   } req_item_type;

   typedef struct packed {
      logic                 reply_kind;
      logic [LENGTH_W-1:0]  icmp_length;
      logic [15:0]          sequence_number;
      logic [7:0]           time_to_live;
      logic [7:0]           message_type;
      logic [7:0]           message_code;
      logic signed [31:0]   rtt_seconds;
      logic [USEC_W-1:0]    rtt_microseconds;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] our_identifier;
      logic        report_other;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/icer_interfaces.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier channels
// Valid/ready interfaces for the byte input, the result and the CSR writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface icer_req_if import icer_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [7:0]        packet_byte;
   logic              last_byte;
   logic [31:0]       recv_seconds;
   logic [USEC_W-1:0] recv_microseconds;

   modport source (output valid, packet_byte, last_byte, recv_seconds,
                   recv_microseconds, input ready);
   modport sink   (input valid, packet_byte, last_byte, recv_seconds,
                   recv_microseconds, output ready);
endinterface

interface icer_rsp_if import icer_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                reply_kind;
   logic [LENGTH_W-1:0] icmp_length;
   logic [15:0]         sequence_number;
   logic [7:0]          time_to_live;
   logic [7:0]          message_type;
   logic [7:0]          message_code;
   logic signed [31:0]  rtt_seconds;
   logic [USEC_W-1:0]   rtt_microseconds;

   modport source (output valid, reply_kind, icmp_length, sequence_number,
                   time_to_live, message_type, message_code, rtt_seconds,
                   rtt_microseconds, input ready);
   modport sink   (input valid, reply_kind, icmp_length, sequence_number,
                   time_to_live, message_type, message_code, rtt_seconds,
                   rtt_microseconds, output ready);
endinterface

interface icer_csr_if import icer_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/icmp_echo_reply_classifier.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier
// Parses an IPv4 packet byte by byte and reports our echo replies with their
// round-trip time, and optionally other ICMP messages.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req      in         packet_byte, last_byte, recv_seconds, recv_microseconds
//  rsp      out        reply_kind, icmp_length, sequence_number, time_to_live,
//                      message_type, message_code, rtt_seconds, rtt_microseconds
//  csr      in         index, data (0 our_identifier, 1 report_other)
//
// One byte transaction is taken every cycle unless rsp stalls. The last byte
// of a packet passes the input register; the result register holds its result.
// Reset clears the packet state, the CSR registers and both valid flags.
// A waiting result stalls the parser, and req once the input register is full.
// The csr channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_reply_classifier import icer_pkg::*; #(
   parameter int MAX_PACKET = MAX_PACKET_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   icer_req_if.sink    req,
   icer_rsp_if.source  rsp,
   icer_csr_if.sink    csr
);

   cfg_type      cfg;
   logic         advance;
   logic         item_valid;
   req_item_type item;

   icer_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   icer_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   icer_parse #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .cfg        (cfg),
      .advance    (advance),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

/* hdl/icer_csr.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier registers
// Holds our identifier and the report-other enable.
// ----------------------------------------------------------------------------
`default_nettype none

module icer_csr import icer_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   icer_csr_if.sink    csr,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to unknown indexes fall through and change nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_OUR_IDENTIFIER: cfg_in.our_identifier = csr.data[15:0];
            CSR_REPORT_OTHER:   cfg_in.report_other   = csr.data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/icer_in_stage.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier input register
// Registers one byte transaction and hands it to the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module icer_in_stage import icer_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   icer_req_if.sink     req,
   input  wire logic    advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req.ready  = !valid_ff || advance;
   assign take       = req.valid && req.ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{packet_byte:       req.packet_byte,
                      last_byte:         req.last_byte,
                      recv_seconds:      req.recv_seconds,
                      recv_microseconds: req.recv_microseconds};
      end
   end

endmodule

`default_nettype wire

/* hdl/icer_parse.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier parser
// Captures header fields by offset, judges the packet on its last byte and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icer_parse import icer_pkg::*; #(
   parameter int MAX_PACKET = MAX_PACKET_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   input  wire req_item_type  item,
   input  wire cfg_type       cfg,
   output logic               advance,
   icer_rsp_if.source         rsp
);

   localparam int CW = $clog2(MAX_PACKET);
   localparam int DW = (CW + 1 > LENGTH_W) ? CW + 1 : LENGTH_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKET - 1);

   logic [CW-1:0] byte_count_ff,   byte_count_in,   cap_count;
   logic [5:0]    header_bytes_ff, header_bytes_in, cap_header;
   logic [7:0]    protocol_ff,     protocol_in,     cap_protocol;
   logic [7:0]    ttl_ff,          ttl_in,          cap_ttl;
   logic [7:0]    type_ff,         type_in,         cap_type;
   logic [7:0]    code_ff,         code_in,         cap_code;
   logic [15:0]   ident_ff,        ident_in,        cap_ident;
   logic [15:0]   seq_ff,          seq_in,          cap_seq;
   logic [31:0]   sent_sec_ff,     sent_sec_in,     cap_sent_sec;
   logic [31:0]   sent_usec_ff,    sent_usec_in,    cap_sent_usec;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff;
   rsp_item_type  result;

   logic          process;
   logic          emit;
   logic [CW-1:0] p;
   logic [7:0]    b;
   logic [CW-1:0] offset;
   logic [DW-1:0] len_ext, hdr_ext, icmp_diff;
   logic          long_enough, reply_long, is_reply;
   logic signed [33:0] usec_diff, usec_fix;
   logic          borrow;
   logic [USEC_W-1:0]  rtt_usec;
   logic [31:0]   rtt_sec;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign process = item_valid && advance;
   assign p       = byte_count_ff;
   assign b       = item.packet_byte;

   // Field capture for the current byte. The header length written by byte 0
   // already applies to byte 0 itself.
   always_comb begin
      cap_count     = byte_count_ff;
      cap_header    = header_bytes_ff;
      cap_protocol  = protocol_ff;
      cap_ttl       = ttl_ff;
      cap_type      = type_ff;
      cap_code      = code_ff;
      cap_ident     = ident_ff;
      cap_seq       = seq_ff;
      cap_sent_sec  = sent_sec_ff;
      cap_sent_usec = sent_usec_ff;
      offset        = '0;
      if (p < CNT_MAX) begin
         cap_count = p + CW'(1);
         if (p == CW'(IP_OFS_VERSION_IHL)) cap_header   = {b[3:0], 2'b00};
         if (p == CW'(IP_OFS_TTL))         cap_ttl      = b;
         if (p == CW'(IP_OFS_PROTOCOL))    cap_protocol = b;
         offset = p - CW'(cap_header);
         if (p >= CW'(cap_header) && offset[CW-1:4] == '0) begin
            case (offset[3:0]) inside
               4'd0:                      cap_type = b;
               4'd1:                      cap_code = b;
               4'd4, 4'd5:                cap_ident[{offset[0], 3'b000} +: 8] = b;
               4'd6, 4'd7:                cap_seq[{offset[0], 3'b000} +: 8] = b;
               4'd8, 4'd9, 4'd10, 4'd11:
                  cap_sent_sec[{offset[1:0], 3'b000} +: 8] = b;
               4'd12, 4'd13, 4'd14, 4'd15:
                  cap_sent_usec[{offset[1:0], 3'b000} +: 8] = b;
               default: ;
            endcase
         end
      end
   end

   // Judgment of the finished packet.
   always_comb begin
      len_ext     = DW'(cap_count);
      hdr_ext     = DW'(cap_header);
      icmp_diff   = len_ext - hdr_ext;
      long_enough = len_ext >= hdr_ext + DW'(ICMP_MIN_LEN);
      reply_long  = len_ext >= hdr_ext + DW'(REPLY_MIN_LEN);
      is_reply    = cap_type == TYPE_ECHO_REPLY;

      // The sent microseconds word is taken as two's complement.
      usec_diff = $signed({14'b0, item.recv_microseconds})
                - $signed({{2{cap_sent_usec[31]}}, cap_sent_usec});
      borrow    = usec_diff < 0;
      usec_fix  = borrow ? usec_diff + $signed(USEC_PER_SEC) : usec_diff;
      if (usec_fix < 0) begin
         rtt_usec = '0;
      end else if (usec_fix > $signed(USEC_MAX)) begin
         rtt_usec = USEC_MAX[USEC_W-1:0];
      end else begin
         rtt_usec = usec_fix[USEC_W-1:0];
      end
      rtt_sec = item.recv_seconds - 32'(borrow) - cap_sent_sec;

      emit = cap_protocol == PROTO_ICMP && long_enough &&
             ((is_reply && cap_ident == cfg.our_identifier && reply_long) ||
              (!is_reply && cfg.report_other));

      result.reply_kind       = is_reply ? KIND_REPLY : KIND_OTHER;
      result.icmp_length      = icmp_diff[LENGTH_W-1:0];
      result.sequence_number  = cap_seq;
      result.time_to_live     = cap_ttl;
      result.message_type     = cap_type;
      result.message_code     = cap_code;
      result.rtt_seconds      = is_reply ? $signed(rtt_sec) : '0;
      result.rtt_microseconds = is_reply ? rtt_usec : '0;
   end

   // Packet state: keeps the captures, cleared after every last byte.
   always_comb begin
      byte_count_in   = byte_count_ff;
      header_bytes_in = header_bytes_ff;
      protocol_in     = protocol_ff;
      ttl_in          = ttl_ff;
      type_in         = type_ff;
      code_in         = code_ff;
      ident_in        = ident_ff;
      seq_in          = seq_ff;
      sent_sec_in     = sent_sec_ff;
      sent_usec_in    = sent_usec_ff;
      if (process) begin
         if (item.last_byte) begin
            byte_count_in   = '0;
            header_bytes_in = '0;
            protocol_in     = '0;
            ttl_in          = '0;
            type_in         = '0;
            code_in         = '0;
            ident_in        = '0;
            seq_in          = '0;
            sent_sec_in     = '0;
            sent_usec_in    = '0;
         end else begin
            byte_count_in   = cap_count;
            header_bytes_in = cap_header;
            protocol_in     = cap_protocol;
            ttl_in          = cap_ttl;
            type_in         = cap_type;
            code_in         = cap_code;
            ident_in        = cap_ident;
            seq_in          = cap_seq;
            sent_sec_in     = cap_sent_sec;
            sent_usec_in    = cap_sent_usec;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process && item.last_byte && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         header_bytes_ff <= '0;
         protocol_ff     <= '0;
         ttl_ff          <= '0;
         type_ff         <= '0;
         code_ff         <= '0;
         ident_ff        <= '0;
         seq_ff          <= '0;
         sent_sec_ff     <= '0;
         sent_usec_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         byte_count_ff   <= byte_count_in;
         header_bytes_ff <= header_bytes_in;
         protocol_ff     <= protocol_in;
         ttl_ff          <= ttl_in;
         type_ff         <= type_in;
         code_ff         <= code_in;
         ident_ff        <= ident_in;
         seq_ff          <= seq_in;
         sent_sec_ff     <= sent_sec_in;
         sent_usec_ff    <= sent_usec_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process && item.last_byte && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.reply_kind       = rsp_ff.reply_kind;
   assign rsp.icmp_length      = rsp_ff.icmp_length;
   assign rsp.sequence_number  = rsp_ff.sequence_number;
   assign rsp.time_to_live     = rsp_ff.time_to_live;
   assign rsp.message_type     = rsp_ff.message_type;
   assign rsp.message_code     = rsp_ff.message_code;
   assign rsp.rtt_seconds      = rsp_ff.rtt_seconds;
   assign rsp.rtt_microseconds = rsp_ff.rtt_microseconds;

endmodule

`default_nettype wire

/* hdl/icer_checker.sv */
// ----------------------------------------------------------------------------
// ICMP echo reply classifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icer_checker import icer_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_reply_kind,
   input wire logic [LENGTH_W-1:0] rsp_icmp_length,
   input wire logic [31:0]         rsp_rtt_seconds,
   input wire logic [USEC_W-1:0]   rsp_rtt_microseconds
);

   // A pending result is held until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_icmp_length))
      else $error("result dropped or changed while stalled");

   a_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rtt_usec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_REPLY |->
         rsp_rtt_microseconds <= USEC_MAX[USEC_W-1:0])
      else $error("round-trip microseconds out of range");

   a_other_no_rtt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_OTHER |->
         rsp_rtt_seconds == '0 && rsp_rtt_microseconds == '0)
      else $error("round-trip time on a non-reply result");

   a_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == KIND_REPLY |->
         rsp_icmp_length >= LENGTH_W'(REPLY_MIN_LEN))
      else $error("echo reply result shorter than the reply minimum");

endmodule

bind icmp_echo_reply_classifier icer_checker u_icer_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_reply_kind       (rsp.reply_kind),
   .rsp_icmp_length      (rsp.icmp_length),
   .rsp_rtt_seconds      (rsp.rtt_seconds),
   .rsp_rtt_microseconds (rsp.rtt_microseconds)
);

`default_nettype wire
